// ----- design/fdc_pkg.sv -----
package fdc_pkg;

    // Field widths fixed by the item and result formats
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int TAP_INDEX_W = 7;
    localparam int TAP_COUNT_W = 8;
    localparam int FUNC_W      = 2;
    localparam int FRAC_W      = 15;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_FILTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COEF   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Register map
    localparam int  APB_ADDR_W    = 3;
    localparam int  APB_DATA_W    = 32;
    localparam logic REG_TAP_COUNT = 1'b0;
    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 8'd1;

    // Q1.15 limits
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic [FUNC_W-1:0]             func;
        logic signed [SAMPLE_W-1:0]    sample_in;
        logic [TAP_INDEX_W-1:0]        tap_index;
        logic signed [SAMPLE_W-1:0]    coefficient;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]    sample_out;
        logic                          saturated;
    } result_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                          shift;
        logic                          clear;
        logic                          coef_we;
        logic [TAP_INDEX_W-1:0]        tap_index;
        logic signed [SAMPLE_W-1:0]    coefficient;
        logic [TAP_COUNT_W-1:0]        tap_count;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_FILTER
    } fdc_state_t;

endpackage

// ----- design/fdc_tap_cell.sv -----
module fdc_tap_cell #(
    parameter int IDX   = 0,
    parameter int ACC_W = 39
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fdc_pkg::cell_ctl_t                    ctl,
    input  logic signed [fdc_pkg::SAMPLE_W-1:0]   x_in,
    output logic signed [fdc_pkg::SAMPLE_W-1:0]   x_out,
    input  logic signed [ACC_W-1:0]               ps_in,
    output logic signed [ACC_W-1:0]               ps_out,
    input  logic                                  tok_in,
    output logic                                  tok_out
);

    localparam bit WRITABLE = (IDX < (2 ** fdc_pkg::TAP_INDEX_W));
    localparam bit COUNTABLE = (IDX < (2 ** fdc_pkg::TAP_COUNT_W));
    localparam logic [fdc_pkg::TAP_INDEX_W-1:0] IDX_W = fdc_pkg::TAP_INDEX_W'(IDX);
    localparam logic [fdc_pkg::TAP_COUNT_W-1:0] IDX_C = fdc_pkg::TAP_COUNT_W'(IDX);

    logic signed [fdc_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [fdc_pkg::SAMPLE_W-1:0] h_reg;
    logic signed [ACC_W-1:0]             ps_reg;
    logic signed [ACC_W-1:0]             ps_next;
    logic                                tok_reg;
    logic signed [fdc_pkg::PROD_W-1:0]   prod;
    logic                                tap_en;
    logic                                coef_hit;

    // Decode this cell's coefficient slot and tap enable
    assign coef_hit = WRITABLE && ctl.coef_we && (ctl.tap_index == IDX_W);
    assign tap_en   = COUNTABLE && (ctl.tap_count > IDX_C);

    // Add this tap's product to the passing partial sum
    assign prod    = h_reg * x_reg;
    assign ps_next = ps_in + (tap_en ? ACC_W'(prod) : ACC_W'(0));

    // Hold history and coefficient, advance the sum wave
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            h_reg   <= '0;
            tok_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                x_reg <= '0;
            end
            else if (ctl.shift)
            begin
                x_reg <= x_in;
            end
            if (coef_hit)
            begin
                h_reg <= ctl.coefficient;
            end
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        ps_reg <= ps_next;
    end

    assign x_out   = x_reg;
    assign ps_out  = ps_reg;
    assign tok_out = tok_reg;

endmodule

// ----- design/fir_direct_convolver_core.sv -----
// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  fdc_pkg::item_t (func, sample, tap, coefficient)
// result    out        result_valid/...stall  fdc_pkg::result_t (sample_out, saturated)
// config    in         APB psel/penable       tap_count at byte address 0
//
// A coefficient write, history clear or unused code starts no sum wave.
// A sample stalls the next item until its result leaves the holding slot: a launch register,
// then the partial sum walks the cell chain one cell per cycle, is rounded into a holding
// slot and moves on to the output register.
// A finished result waits in the output register while the next item is accepted.
// rst_n clears the sample history, all coefficients and sets tap_count to 1.
// A stalled result holds; items stall while a sum is in flight or the holding slot is full.
module fir_direct_convolver_core #(
    parameter int MAX_TAPS = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fdc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fdc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fdc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  fdc_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output fdc_pkg::result_t                   result
);

    localparam int ACC_W = fdc_pkg::PROD_W + $clog2(MAX_TAPS);
    localparam int SH_W  = ACC_W - fdc_pkg::FRAC_W;

    logic [fdc_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    logic                            cfg_write;

    fdc_pkg::fdc_state_t state_reg;
    fdc_pkg::fdc_state_t state_next;

    logic                 item_xfer;
    logic                 is_sample;
    logic                 start_reg;
    logic                 start_next;
    fdc_pkg::cell_ctl_t   ctl;

    logic signed [fdc_pkg::SAMPLE_W-1:0] x_chain [0:MAX_TAPS];
    logic signed [ACC_W-1:0]             ps_chain [0:MAX_TAPS];
    logic [MAX_TAPS:0]                   tok_chain;
    logic                                tok_last;

    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [SH_W-1:0]  rnd_shift;
    fdc_pkg::result_t        rnd_result;

    logic               pend_valid_reg;
    logic               pend_valid_next;
    fdc_pkg::result_t   pend_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    fdc_pkg::result_t   out_data_reg;
    logic               pend_move;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fdc_pkg::TAP_COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == fdc_pkg::REG_TAP_COUNT))
        begin
            tap_count_reg <= pwdata[fdc_pkg::TAP_COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            fdc_pkg::REG_TAP_COUNT:
                prdata = fdc_pkg::APB_DATA_W'(tap_count_reg);
            default:
                prdata = '0;
        endcase
    end

    // Sequencer
    assign item_xfer = item_valid && !item_stall;
    assign is_sample = (item.func == fdc_pkg::FUNC_FILTER);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdc_pkg::ST_IDLE:
                if (item_xfer && is_sample)
                begin
                    state_next = fdc_pkg::ST_FILTER;
                end
            fdc_pkg::ST_FILTER:
                if (tok_last)
                begin
                    state_next = fdc_pkg::ST_IDLE;
                end
            default:
                state_next = fdc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall = 1'b1;
        start_next = 1'b0;
        unique case (state_reg)
            fdc_pkg::ST_IDLE:
            begin
                item_stall = pend_valid_reg;
                start_next = item_xfer && is_sample;
            end
            fdc_pkg::ST_FILTER:
            begin
                item_stall = 1'b1;
                start_next = 1'b0;
            end
            default:
            begin
                item_stall = 1'b1;
                start_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdc_pkg::ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    // Broadcast control to the cells
    always_comb
    begin
        ctl.shift       = item_xfer && is_sample;
        ctl.clear       = item_xfer && (item.func == fdc_pkg::FUNC_CLEAR);
        ctl.coef_we     = item_xfer && (item.func == fdc_pkg::FUNC_COEF);
        ctl.tap_index   = item.tap_index;
        ctl.coefficient = item.coefficient;
        ctl.tap_count   = tap_count_reg;
    end

    // Cell chain: history shifts right, partial sum wave runs right
    assign x_chain[0]   = item.sample_in;
    assign ps_chain[0]  = '0;
    assign tok_chain[0] = start_reg;

    for (genvar i = 0; i < MAX_TAPS; i++)
    begin : g_cell
        fdc_tap_cell #(
            .IDX   (i),
            .ACC_W (ACC_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .x_in    (x_chain[i]),
            .x_out   (x_chain[i+1]),
            .ps_in   (ps_chain[i]),
            .ps_out  (ps_chain[i+1]),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1])
        );
    end

    assign tok_last = tok_chain[MAX_TAPS];

    // Round half up and saturate to Q1.15
    assign rnd_sum   = ps_chain[MAX_TAPS] + ACC_W'(2 ** (fdc_pkg::FRAC_W - 1));
    assign rnd_shift = SH_W'(rnd_sum >>> fdc_pkg::FRAC_W);

    always_comb
    begin
        if (rnd_shift > SH_W'(fdc_pkg::SAMPLE_MAX))
        begin
            rnd_result.sample_out = fdc_pkg::SAMPLE_MAX;
            rnd_result.saturated  = 1'b1;
        end
        else if (rnd_shift < SH_W'(fdc_pkg::SAMPLE_MIN))
        begin
            rnd_result.sample_out = fdc_pkg::SAMPLE_MIN;
            rnd_result.saturated  = 1'b1;
        end
        else
        begin
            rnd_result.sample_out = rnd_shift[fdc_pkg::SAMPLE_W-1:0];
            rnd_result.saturated  = 1'b0;
        end
    end

    // Holding slot and output register
    assign pend_move = pend_valid_reg && (!out_valid_reg || !result_stall);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (tok_last)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_last)
        begin
            pend_data_reg <= rnd_result;
        end
        if (pend_move)
        begin
            out_data_reg <= pend_data_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Only one sum wave is ever in flight
    a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_chain))
        else $error("more than one partial sum wave in the cell chain");

    // A held result and a running wave never coexist
    a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_valid_reg && (state_reg == fdc_pkg::ST_FILTER)))
        else $error("wave running while a result is held");

    // A sample transfer launches a wave in the next cycle
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && is_sample) |=> (start_reg && (state_reg == fdc_pkg::ST_FILTER)))
        else $error("sample accepted without launching a wave");

    // A result enters the holding slot only at the end of a wave
    a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_valid_reg) |-> $past(tok_last))
        else $error("result held without a finished wave");

endmodule

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fdc_pkg::*;

    localparam int MAX_TAPS    = 128;
    localparam int LATENCY     = MAX_TAPS + 4;
    localparam int LIMIT       = 400000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 43;
    localparam int DIR_ROWS    = 21;

    localparam logic [FUNC_W-1:0]     FUNC_UNUSED    = 2'd3;
    localparam logic [APB_ADDR_W-1:0] TAP_COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_TAP_COUNT));

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr        = '0;
    logic [APB_DATA_W-1:0]   pwdata       = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    item_valid   = 1'b0;
    logic                    item_stall;
    item_t                   item         = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    result_t                 result;

    // Filter model state
    logic signed [SAMPLE_W-1:0] hist_model [MAX_TAPS] = '{default: '0};
    logic signed [SAMPLE_W-1:0] coef_model [MAX_TAPS] = '{default: '0};
    logic [TAP_COUNT_W-1:0]     taps_model = TAP_COUNT_RESET;

    result_t pending_outputs [$];
    int      err_count   = 0;
    int      cycle_count = 0;
    int      stall_left  = 0;
    bit      idle_on     = 1'b0;

    // Directed rows: typed expectation where it is obvious, else use the model
    typedef struct packed {
        item_t   stim;
        logic    typed;
        result_t want;
    } dir_row_t;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{'{FUNC_FILTER, 16'sh7fff, 7'd0,   16'sh0000}, 1'b1, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'sh8000, 7'd0,   16'sh0000}, 1'b1, '{16'sh0000, 1'b0}},
        '{'{FUNC_COEF,   16'sh0000, 7'd0,   16'sh7fff}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'sh7fff, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'sh8000, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_COEF,   16'sh0000, 7'd0,   16'sh8000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'sh8000, 7'd0,   16'sh0000}, 1'b1, '{16'sh7fff, 1'b1}},
        '{'{FUNC_FILTER, 16'sh7fff, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'sh0000, 7'd0,   16'sh0000}, 1'b1, '{16'sh0000, 1'b0}},
        '{'{FUNC_COEF,   16'sh0000, 7'd127, 16'sh7fff}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_COEF,   16'sh0000, 7'd1,   16'sh8000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_UNUSED, 16'shffff, 7'd127, 16'shffff}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_CLEAR,  16'sh0000, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'sh0001, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_COEF,   16'sh0000, 7'd0,   16'sh4000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'sh0001, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'shffff, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_COEF,   16'sh0000, 7'd85,  16'sh5555}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_COEF,   16'sh0000, 7'd42,  16'shaaaa}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'sh5555, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
        '{'{FUNC_FILTER, 16'shaaaa, 7'd0,   16'sh0000}, 1'b0, '{16'sh0000, 1'b0}}
    };

    logic [TAP_COUNT_W-1:0] tap_plan [NUM_PHASES] = '{
        8'd0, 8'd128, 8'd255, 8'd1, 8'd2, 8'd127, 8'd0, 8'd64, 8'd8, 8'd0
    };

    fir_direct_convolver_core #(
        .MAX_TAPS(MAX_TAPS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Apply one item to the model; return 1 when it yields a filtered sample
    function automatic bit fir_predict(input item_t x, output result_t r);
        longint acc;
        longint y;
        int     n;
        r   = '0;
        acc = 0;
        case (x.func)
            FUNC_COEF:
            begin
                if (int'(x.tap_index) < MAX_TAPS)
                    coef_model[x.tap_index] = x.coefficient;
                return 1'b0;
            end
            FUNC_CLEAR:
            begin
                foreach (hist_model[k])
                    hist_model[k] = '0;
                return 1'b0;
            end
            FUNC_FILTER:
            begin
                n = (int'(taps_model) > MAX_TAPS) ? MAX_TAPS : int'(taps_model);
                for (int k = MAX_TAPS - 1; k > 0; k--)
                    hist_model[k] = hist_model[k-1];
                hist_model[0] = x.sample_in;
                for (int k = 0; k < n; k++)
                    acc += longint'(coef_model[k]) * longint'(hist_model[k]);
                // Round half up, then clip to Q1.15
                y = (acc + 64'sd16384) >>> FRAC_W;
                if (y > longint'(SAMPLE_MAX))
                begin
                    r.sample_out = SAMPLE_MAX;
                    r.saturated  = 1'b1;
                end
                else if (y < longint'(SAMPLE_MIN))
                begin
                    r.sample_out = SAMPLE_MIN;
                    r.saturated  = 1'b1;
                end
                else
                begin
                    r.sample_out = 16'(y);
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Favor full-scale values now and then to hit saturation
    function automatic logic signed [SAMPLE_W-1:0] rand_q15();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t x;
        int    pick;
        x.sample_in   = rand_q15();
        x.tap_index   = TAP_INDEX_W'($urandom_range(0, MAX_TAPS - 1));
        x.coefficient = rand_q15();
        pick          = $urandom_range(0, 99);
        if (pick < 66)
            x.func = FUNC_FILTER;
        else if (pick < 90)
            x.func = FUNC_COEF;
        else if (pick < 94)
            x.func = FUNC_CLEAR;
        else
            x.func = FUNC_UNUSED;
        return x;
    endfunction

    // Hold the item until the transfer, then predict its output
    task automatic send_item(input item_t x, output bit has, output result_t r);
        item       <= x;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        has = fir_predict(x, r);
    endtask

    // Drop valid for a random burst
    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    // Wait for all outputs, then let any trailing work settle
    task automatic drain_filter();
        item_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
    endtask

    // Write tap_count over the register port and read it back
    task automatic write_tap_count(input logic [TAP_COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TAP_COUNT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[TAP_COUNT_W-1:0] !== value)
        begin
            $error("tap_count readback: expected %0d, actual %0d",
                   value, prdata[TAP_COUNT_W-1:0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        taps_model = value;
    endtask

    // Check each output transfer and drive random stall bursts
    always @(posedge clk)
    begin
        result_t want;
        if (result_valid && !result_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected output: sample_out %0d saturated %0b",
                       result.sample_out, result.saturated);
                err_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result.sample_out !== want.sample_out)
                begin
                    $error("sample_out: expected %0d, actual %0d",
                           want.sample_out, result.sample_out);
                    err_count++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, actual %0b",
                           want.saturated, result.saturated);
                    err_count++;
                end
            end
        end
        if (stall_left > 0)
            stall_left--;
        else if (idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 18);
        result_stall <= (stall_left > 0);
    end

    initial
    begin
        bit                     has;
        result_t                r;
        item_t                  x;
        logic [TAP_COUNT_W-1:0] tap_setting;
        int                     n;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // Walk the directed table at the reset tap count
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_item(dir_table[i].stim, has, r);
            if (has)
                pending_outputs.push_back(dir_table[i].typed ? dir_table[i].want : r);
            sender_gap();
        end
        drain_filter();

        // Random phases, each at its own tap count; last one runs without idling
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            if (p == 6)
                tap_setting = TAP_COUNT_W'($urandom_range(3, MAX_TAPS - 2));
            else if (p == NUM_PHASES - 1)
                tap_setting = TAP_COUNT_W'($urandom_range(0, 255));
            else
                tap_setting = tap_plan[p];
            write_tap_count(tap_setting);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                x = rand_item();
                send_item(x, has, r);
                if (has)
                    pending_outputs.push_back(r);
                if (x.func != FUNC_UNUSED)
                    n++;
                sender_gap();
            end
            drain_filter();
        end

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
